### rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the prefix-function stream block.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // Width of the reported prefix length
    localparam int PREFIX_W = 8;

    // Sequencer state
    typedef logic [0:0] state_t;

    localparam state_t ST_IDLE = 1'b0;
    localparam state_t ST_SCAN = 1'b1;

endpackage

### rtl/prefix_function_stream.sv
// ----------------------------------------------------------------------------
// prefix_function_stream
// Online prefix function over a stored string.
//
// Input channel s_*: one symbol per item. With s_start_req high, the symbol
// opens a new string. Result channel m_*: exactly one item per input item,
// carrying the prefix-function value at the new position (low 8 bits) and
// an overflow flag set when the string was already MAX_LEN long and the
// symbol was dropped.
// A start symbol or a dropped symbol yields its result in the cycle after
// acceptance; the sequencer stays idle, so the next item can be taken as soon as that result is drained.
// Otherwise the block walks the failure chain, one chain entry per cycle,
// through a single read port on each of the symbol store and the prefix
// store: the accept in ST_IDLE fetches the first entry, each ST_SCAN cycle
// compares one fetched entry, and a match or the end of the chain writes
// both stores, registers the result and returns the sequencer to idle.
// s_ready is high only while the sequencer is idle and the result register
// is empty or being drained; a stalled receiver therefore holds off input.
// Reset clears the string length and the control state; the stores are not
// cleared, since only entries already written are used.
// ----------------------------------------------------------------------------
module prefix_function_stream #(
    parameter int MAX_LEN     = 256,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SYMBOL_BITS-1:0]        s_symbol,
    input  logic                          s_start_req,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pfs_pkg::PREFIX_W-1:0]  m_prefix_length,
    output logic                          m_overflow
);
    import pfs_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int EXT_W = IDX_W + PREFIX_W;

    // Stores
    logic [SYMBOL_BITS-1:0] sym_mem [MAX_LEN];
    logic [IDX_W-1:0]       pre_mem [MAX_LEN];

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [IDX_W-1:0]       last_val_reg, last_val_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic [SYMBOL_BITS-1:0] rd_sym_reg;
    logic [IDX_W-1:0]       rd_pre_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]       res_val_reg, res_val_next;
    logic                   res_ovf_reg, res_ovf_next;

    logic                   accept;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [SYMBOL_BITS-1:0] wr_sym;
    logic [IDX_W-1:0]       wr_pre;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       rd_addr_m1;
    logic [EXT_W-1:0]       res_ext;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Chain candidate: last value on entry, then the fetched failure link
    assign rd_addr    = (state_reg == ST_IDLE) ? last_val_reg : rd_pre_reg;
    assign rd_addr_m1 = rd_addr - IDX_W'(1);

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        last_val_next = last_val_reg;
        cur_next      = cur_reg;
        sym_next      = sym_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        res_val_next  = res_val_reg;
        res_ovf_next  = res_ovf_reg;
        wr_en         = 1'b0;
        wr_addr       = len_reg[IDX_W-1:0];
        wr_sym        = sym_reg;
        wr_pre        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (s_start_req || len_reg == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_sym        = s_symbol;
                        wr_pre        = '0;
                        len_next      = LEN_W'(1);
                        last_val_next = '0;
                        m_valid_next  = 1'b1;
                        res_val_next  = '0;
                        res_ovf_next  = 1'b0;
                    end else if (len_reg == LEN_W'(MAX_LEN)) begin
                        m_valid_next = 1'b1;
                        res_val_next = '0;
                        res_ovf_next = 1'b1;
                    end else begin
                        sym_next   = s_symbol;
                        cur_next   = last_val_reg;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_sym_reg == sym_reg || cur_reg == '0) begin
                    wr_en         = 1'b1;
                    wr_pre        = (rd_sym_reg == sym_reg) ? cur_reg + IDX_W'(1) : '0;
                    len_next      = len_reg + LEN_W'(1);
                    last_val_next = wr_pre;
                    m_valid_next  = 1'b1;
                    res_val_next  = wr_pre;
                    res_ovf_next  = 1'b0;
                    state_next    = ST_IDLE;
                end else begin
                    // mismatch: follow failure link, its entries were read this cycle
                    cur_next = rd_pre_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            last_val_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            last_val_reg <= last_val_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        sym_reg     <= sym_next;
        res_val_reg <= res_val_next;
        res_ovf_reg <= res_ovf_next;
    end

    // Store ports: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sym_mem[wr_addr] <= wr_sym;
            pre_mem[wr_addr] <= wr_pre;
        end
        rd_sym_reg <= sym_mem[rd_addr];
        rd_pre_reg <= pre_mem[rd_addr_m1];
    end

    assign res_ext         = EXT_W'(res_val_reg);
    assign m_valid         = m_valid_reg;
    assign m_prefix_length = res_ext[PREFIX_W-1:0];
    assign m_overflow      = res_ovf_reg;

endmodule

### tb/tb_prefix_function_stream.sv
// ----------------------------------------------------------------------------
// tb_prefix_function_stream
// Self-checking bench for the online prefix-function block. A behavioral
// predictor tracks the stored string and computes the expected prefix length
// and overflow flag for every accepted symbol. Directed strings exercise the
// first symbol, a missing start after reset, long failure chains and a full
// string. Random strings over small alphabets follow, with idle and stall
// phases on both channels.
// ----------------------------------------------------------------------------
module tb_prefix_function_stream;

    localparam int MAX_LEN     = 256;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct {
        logic [pfs_pkg::PREFIX_W-1:0] prefix_length;
        logic                         overflow;
    } prefix_result_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_symbol    = '0;
    logic                         s_start_req = 1'b0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [pfs_pkg::PREFIX_W-1:0] m_prefix_length;
    logic                         m_overflow;

    // shadow of the string held by the block
    logic [7:0]     sym_hist [MAX_LEN];
    int             prefix_hist [MAX_LEN];
    int             str_len;

    prefix_result_t expected_q [$];
    int             err_count      = 0;
    int             cycle_count    = 0;
    int             src_idle_pct   = 0;
    int             sink_stall_pct = 0;

    prefix_function_stream #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (8)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol        (s_symbol),
        .s_start_req     (s_start_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prefix_length (m_prefix_length),
        .m_overflow      (m_overflow)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    // result checker and receiver back-pressure
    always @(posedge aclk) begin
        prefix_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item, prefix_length", int'(m_prefix_length), -1);
            end else begin
                want = expected_q.pop_front();
                if (m_prefix_length !== want.prefix_length)
                    report_mismatch("prefix_length", int'(m_prefix_length),
                                    int'(want.prefix_length));
                if (m_overflow !== want.overflow)
                    report_mismatch("overflow", int'(m_overflow), int'(want.overflow));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // appends one symbol to the shadow string and returns the expected item
    function automatic prefix_result_t next_prefix(input logic [7:0] sym, input logic start);
        prefix_result_t res;
        int pos;
        int cur;
        int nxt;
        int val;
        res.prefix_length = '0;
        res.overflow      = 1'b0;
        if (start || str_len == 0) begin
            sym_hist[0]    = sym;
            prefix_hist[0] = 0;
            str_len        = 1;
        end else if (str_len >= MAX_LEN) begin
            res.overflow = 1'b1;
        end else begin
            pos = str_len;
            cur = prefix_hist[pos-1];
            if (cur >= pos)
                cur = 0;
            // follow the failure chain until the symbol matches or it runs out
            while (cur > 0 && sym_hist[cur] != sym) begin
                nxt = prefix_hist[cur-1];
                cur = (nxt < cur) ? nxt : 0;
            end
            val = (sym_hist[cur] == sym) ? cur + 1 : 0;
            sym_hist[pos]     = sym;
            prefix_hist[pos]  = val;
            str_len           = pos + 1;
            res.prefix_length = val[7:0];
        end
        return res;
    endfunction

    task automatic send_symbol(input logic [7:0] sym, input logic start);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_symbol    <= sym;
        s_start_req <= start;
        do @(posedge aclk); while (!(s_valid && s_ready));
        expected_q.push_back(next_prefix(sym, start));
    endtask

    task automatic test_start_without_request();
        // fresh after reset, no start flag: still opens a string
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
    endtask

    task automatic test_chain_walk();
        logic [7:0] pat [9] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                                8'h00, 8'h00, 8'h00};
        foreach (pat[i])
            send_symbol(pat[i], i == 0);
        // restart mid-string, then alternate the symbols either side of the field's midpoint
        send_symbol(8'h80, 1'b1);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'h01, 1'b0);
    endtask

    task automatic test_full_string();
        // one repeated symbol drives the prefix length up to its maximum
        for (int i = 0; i < MAX_LEN; i++)
            send_symbol(8'hA5, i == 0);
        send_symbol(8'hA5, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h5A, 1'b1);
        send_symbol(8'h5A, 1'b0);
    endtask

    // periodic strings over small random alphabets give long failure chains;
    // a few mutations, stray restarts and over-long strings act as noise
    task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                       input int n_items);
        logic [7:0] alph [4];
        logic [7:0] pat [8];
        int         sent;
        int         len;
        int         per;
        int         n_alph;
        logic [7:0] sym;
        logic       start;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            n_alph = $urandom_range(1, 4);
            foreach (alph[i])
                alph[i] = 8'($urandom_range(0, 255));
            per = $urandom_range(1, 8);
            foreach (pat[i])
                pat[i] = alph[$urandom_range(0, n_alph - 1)];
            len = ($urandom_range(0, 99) < 4) ? $urandom_range(250, 270)
                                              : $urandom_range(1, 48);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : alph[$urandom_range(0, n_alph - 1)];
                else
                    sym = pat[i % per];
                start = (i == 0) ? ($urandom_range(0, 19) != 0)
                                 : ($urandom_range(0, 99) == 0);
                send_symbol(sym, start);
            end
            sent += len;
        end
    endtask

    initial begin
        str_len = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_start_without_request();
        test_chain_walk();
        test_full_string();
        test_random_strings(0, 0, 140);
        test_random_strings(48, 0, 130);
        test_random_strings(0, 48, 130);
        test_random_strings(12, 12, 130);

        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/pfs_pkg.sv
rtl/prefix_function_stream.sv
tb/tb_prefix_function_stream.sv
